[hdl/led_pwm_animation_controller_defines.svh]
// Assertion macros for the LED PWM animation controller
`ifndef LED_PWM_ANIMATION_CONTROLLER_DEFINES_SVH
`define LED_PWM_ANIMATION_CONTROLLER_DEFINES_SVH
// implication checked every clock outside reset
`define LPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked every clock outside reset
`define LPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/lpa_pkg.sv]
// Package: payload types, mode and phase codes for the LED animation controller
`timescale 1ns / 1ps
package lpa_pkg;
    localparam int RampStepBitsDef = 8;
    localparam int BrightBitsDef   = 16;
    localparam int LevelBitsDef    = 8;
    localparam int TickBitsDef     = 16;

    localparam logic [1:0] M_OFF    = 2'd0;
    localparam logic [1:0] M_SOLID  = 2'd1;
    localparam logic [1:0] M_FLASH  = 2'd2;
    localparam logic [1:0] M_BREATH = 2'd3;

    localparam logic [2:0] PH_IN      = 3'd0;
    localparam logic [2:0] PH_HOLDIN  = 3'd1;
    localparam logic [2:0] PH_OUT     = 3'd2;
    localparam logic [2:0] PH_HOLDOUT = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [1:0]        command;
        logic              force_now;
        logic [7:0]        duty;
        logic [15:0]       on_ticks;
        logic [15:0]       off_ticks;
        logic signed [7:0] flash_times;
        logic              start_on;
        logic [15:0]       period_ticks;
        logic [15:0]       hold_in_ticks;
        logic [15:0]       hold_out_ticks;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_duty;
        logic [1:0]  mode;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic        is_cmd;
        logic        force_now;
        logic [2:0]  code;     // 0 none, else command + 1
        logic [47:0] timings;
        logic [16:0] shape;    // duty | times<<8 | start_on<<16
    } t_work;
endpackage

[hdl/lpa_front.sv]
// Front end: accepts input transactions, packs commands, feeds a two-entry queue
`timescale 1ns / 1ps
module lpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lpa_pkg::t_in_item i_item,
    output logic              o_q_valid,
    output lpa_pkg::t_work    o_q_work,
    input  logic              i_q_pop
);
    import lpa_pkg::*;

    t_work      r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_work      w_cls;
    logic       w_push;

    always_comb begin
        w_cls = '0;
        w_cls.is_cmd = (i_item.kind == KIND_CMD);
        w_cls.force_now = i_item.force_now;
        w_cls.code = {1'b0, i_item.command} + 3'd1;
        case (i_item.command)
            M_SOLID: w_cls.shape = {9'd0, i_item.duty};
            M_FLASH: begin
                w_cls.timings = {16'd0, i_item.off_ticks, i_item.on_ticks};
                w_cls.shape = {i_item.start_on, i_item.flash_times, i_item.duty};
            end
            M_BREATH: begin
                w_cls.timings = {i_item.hold_out_ticks, i_item.hold_in_ticks,
                                 i_item.period_ticks};
                w_cls.shape = {9'd0, i_item.duty};
            end
            default: ;
        endcase
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_work  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cls;
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

[hdl/lpa_back.sv]
// Back end: animation sequencer with two multipliers used in turn and an output register
`timescale 1ns / 1ps
module lpa_back #(
    parameter int RAMP_STEP_BITS = lpa_pkg::RampStepBitsDef,
    parameter int BRIGHT_BITS    = lpa_pkg::BrightBitsDef,
    parameter int LEVEL_BITS     = lpa_pkg::LevelBitsDef,
    parameter int TICK_BITS      = lpa_pkg::TickBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_max_pulse,
    input  logic               i_q_valid,
    input  lpa_pkg::t_work     i_q_work,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output lpa_pkg::t_out_item o_item
);
    import lpa_pkg::*;

    localparam int TB = TICK_BITS;
    localparam int BB = BRIGHT_BITS + 1;
    localparam logic [BB-1:0] BrightFull = BB'(1) << BRIGHT_BITS;
    localparam logic [TB-1:0] TickMax = '1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1; // max_pulse * x
    localparam logic [2:0] S_MUL2 = 3'd2; // (prev >> BRIGHT) * level
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]    r_st;
    logic [1:0]    r_mode;
    logic          r_cfgd;
    logic [TB-1:0] r_tcnt;
    logic [2:0]    r_acode, r_pcode;
    logic [47:0]   r_atim, r_ptim;
    logic [16:0]   r_ashp, r_pshp;
    logic [7:0]    r_fleft;
    logic          r_lit;
    logic [2:0]    r_ph;
    logic [TB-1:0] r_tps, r_ramp, r_phold, r_dhold, r_stc;
    logic [BB-1:0] r_bri;
    logic [10:0]   r_bstep;
    logic [15:0]   r_duty;
    logic          r_mul_br;   // pending multiply uses brightness path
    logic [BB-1:0] r_mul_x;
    logic [7:0]    r_lvl;
    logic [BB+15:0] r_prod;
    logic          r_ovalid;
    t_out_item     r_oitem;

    logic [TB-1:0] w_t0, w_t1, w_t2;
    assign w_t0 = TB'(r_atim[15:0]);
    assign w_t1 = TB'(r_atim[31:16]);
    assign w_t2 = TB'(r_atim[47:32]);

    // breath configuration arithmetic
    logic [TB+1:0] w_hsum, w_half;
    logic [TB+1:0] w_tps;
    logic [TB-1:0] w_ramp;
    logic signed [TB+3:0] w_err, w_ph, w_dh;
    logic [TB-1:0] w_phs, w_dhs;
    always_comb begin
        w_hsum = (TB+2)'(w_t1) + (TB+2)'(w_t2);
        w_half = (w_hsum > (TB+2)'(w_t0)) ? '0 : (((TB+2)'(w_t0) - w_hsum) >> 1);
        w_tps  = (w_half + (TB+2)'(1 << (RAMP_STEP_BITS-1))) >> RAMP_STEP_BITS;
        w_ramp = TB'(w_tps << RAMP_STEP_BITS);
        w_err  = $signed({2'b0, w_half}) - $signed((TB+4)'(w_ramp));
        w_ph   = $signed((TB+4)'(w_t1)) + w_err;
        w_dh   = $signed((TB+4)'(w_t2)) + w_err;
        w_phs  = (w_ph < 0) ? '0 : (w_ph > $signed((TB+4)'(TickMax))) ? TickMax : TB'(w_ph);
        w_dhs  = (w_dh < 0) ? '0 : (w_dh > $signed((TB+4)'(TickMax))) ? TickMax : TB'(w_dh);
    end

    logic w_busy;
    assign w_busy = r_ovalid && i_stall;
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid && !w_busy;
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    // tick processing into next-state variables
    logic [1:0]    n_mode;
    logic          n_cfgd, n_lit;
    logic [TB-1:0] n_tcnt, n_tps, n_ramp, n_phold, n_dhold, n_stc;
    logic [2:0]    n_acode, n_pcode, n_ph;
    logic [47:0]   n_atim, n_ptim;
    logic [16:0]   n_ashp, n_pshp;
    logic [7:0]    n_fleft;
    logic [BB-1:0] n_bri;
    logic [10:0]   n_bstep;
    logic [15:0]   n_duty;
    logic          n_mul, n_mul_br;
    logic [BB-1:0] n_mul_x;
    logic [BB:0]   w_bsum;
    logic [7:0]    w_lvl;
    logic          w_son;

    always_comb begin
        n_mode = r_mode; n_cfgd = r_cfgd; n_lit = r_lit; n_tcnt = r_tcnt;
        n_tps = r_tps; n_ramp = r_ramp; n_phold = r_phold; n_dhold = r_dhold;
        n_stc = r_stc; n_acode = r_acode; n_pcode = r_pcode; n_ph = r_ph;
        n_atim = r_atim; n_ptim = r_ptim; n_ashp = r_ashp; n_pshp = r_pshp;
        n_fleft = r_fleft; n_bri = r_bri; n_bstep = r_bstep; n_duty = r_duty;
        n_mul = 1'b0; n_mul_br = 1'b0; n_mul_x = '0; w_bsum = '0;
        w_lvl = r_ashp[7:0];
        w_son = r_ashp[16];
        if (r_tcnt != '0) n_tcnt = r_tcnt - TB'(1);
        if (r_mode == M_OFF) begin
            if (!r_cfgd) begin
                n_duty = '0;
                if (r_acode == 3'd1) n_acode = 3'd0;
                n_cfgd = 1'b1;
            end
            if (n_acode >= 3'd2) begin
                n_mode = 2'(n_acode - 3'd1);
                n_acode = 3'd0; n_cfgd = 1'b0; n_tcnt = '0;
            end
        end else if (r_acode != 3'd0) begin
            n_mode = M_OFF; n_cfgd = 1'b0; n_tcnt = '0;
        end else if (r_mode == M_SOLID) begin
            if (!r_cfgd) begin
                n_mul = 1'b1; n_mul_x = BB'(w_lvl); n_cfgd = 1'b1;
            end
            if (r_pcode != 3'd0) begin
                n_acode = r_pcode; n_atim = r_ptim; n_ashp = r_pshp;
                n_pcode = '0; n_ptim = '0; n_pshp = '0;
            end
        end else if (r_mode == M_FLASH) begin
            if (!r_cfgd) begin
                n_fleft = r_ashp[15:8];
                if (w_son) begin
                    n_tcnt = w_t0; n_mul = 1'b1; n_mul_x = BB'(w_lvl); n_lit = 1'b1;
                end else begin
                    n_tcnt = w_t1; n_duty = '0; n_lit = 1'b0;
                end
                n_cfgd = 1'b1;
            end
            if (r_ashp[15]) n_fleft = 8'hFF;
            if (n_tcnt == '0) begin
                if (n_fleft == 8'd0) begin
                    // a lit start that ends at once keeps its level
                    if (r_pcode != 3'd0) begin
                        n_acode = r_pcode; n_atim = r_ptim; n_ashp = r_pshp;
                        n_pcode = '0; n_ptim = '0; n_pshp = '0;
                    end
                    n_mode = M_OFF; n_cfgd = 1'b0;
                end else if (n_lit) begin
                    n_duty = '0; n_lit = 1'b0; n_tcnt = w_t1; n_mul = 1'b0;
                    if (w_son) n_fleft = n_fleft - 8'd1;
                end else begin
                    n_mul = 1'b1; n_mul_x = BB'(w_lvl); n_lit = 1'b1; n_tcnt = w_t0;
                    if (!w_son) n_fleft = n_fleft - 8'd1;
                end
            end
        end else if (!r_cfgd) begin
            n_tps = TB'(w_tps); n_ramp = w_ramp; n_phold = w_phs; n_dhold = w_dhs;
            n_stc = '0; n_bstep = 11'd1; n_bri = '0; n_tcnt = w_ramp;
            n_ph = PH_IN; n_cfgd = 1'b1;
        end else begin
            case (r_ph)
                PH_IN, PH_OUT: begin
                    if (n_tcnt == '0) begin
                        n_stc = '0;
                        if (r_ph == PH_IN) begin
                            n_mul = 1'b1; n_mul_x = BB'(w_lvl); n_tcnt = r_phold;
                            n_bstep = (r_bstep >= 11'd2) ? r_bstep - 11'd2 : 11'd0;
                            n_ph = PH_HOLDIN;
                        end else begin
                            n_duty = '0; n_tcnt = r_dhold; n_bstep = 11'd1;
                            n_bri = '0; n_ph = PH_HOLDOUT;
                        end
                    end else begin
                        n_stc = r_stc + TB'(1);
                        if (n_stc >= r_tps) begin
                            if (r_ph == PH_IN) begin
                                w_bsum = {1'b0, r_bri} + (BB+1)'(r_bstep);
                                n_bri = (w_bsum > (BB+1)'(BrightFull)) ? BrightFull
                                                                        : BB'(w_bsum);
                                n_bstep = r_bstep + 11'd2;
                            end else if (r_bri >= BB'(r_bstep)) begin
                                n_bri = r_bri - BB'(r_bstep);
                                if (r_bstep > 11'd1) n_bstep = r_bstep - 11'd2;
                            end
                            n_mul = 1'b1; n_mul_br = 1'b1; n_mul_x = n_bri;
                            n_stc = '0;
                        end
                    end
                end
                PH_HOLDIN: if (n_tcnt == '0) begin n_tcnt = r_ramp; n_ph = PH_OUT; end
                PH_HOLDOUT: if (n_tcnt == '0) begin
                    n_tcnt = r_ramp; n_ph = PH_DONE;
                    if (r_pcode != 3'd0) begin
                        n_acode = r_pcode; n_atim = r_ptim; n_ashp = r_pshp;
                        n_pcode = '0; n_ptim = '0; n_pshp = '0;
                    end
                end
                default: n_mode = M_OFF;
            endcase
        end
    end

    logic [BB+15:0] w_p1;
    logic [BB+15:0] w_p2;
    assign w_p1 = (BB+16)'(i_max_pulse) * (BB+16)'(r_mul_x);
    assign w_p2 = (BB+16)'(16'(r_prod >> BRIGHT_BITS)) * (BB+16)'(r_lvl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mode <= M_OFF; r_cfgd <= 1'b0; r_tcnt <= '0;
            r_acode <= '0; r_pcode <= '0; r_atim <= '0; r_ptim <= '0;
            r_ashp <= '0; r_pshp <= '0; r_fleft <= '0; r_lit <= 1'b0;
            r_ph <= PH_IN; r_tps <= '0; r_ramp <= '0; r_phold <= '0;
            r_dhold <= '0; r_stc <= '0; r_bri <= '0; r_bstep <= 11'd1;
            r_duty <= '0; r_ovalid <= 1'b0; r_mul_br <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (o_q_pop) begin
                    if (i_q_work.is_cmd) begin
                        if (i_q_work.force_now) begin
                            r_acode <= i_q_work.code; r_atim <= i_q_work.timings;
                            r_ashp <= i_q_work.shape;
                        end else begin
                            r_pcode <= i_q_work.code; r_ptim <= i_q_work.timings;
                            r_pshp <= i_q_work.shape;
                        end
                        r_st <= S_OUT;
                    end else begin
                        r_mode <= n_mode; r_cfgd <= n_cfgd; r_lit <= n_lit;
                        r_tcnt <= n_tcnt; r_tps <= n_tps; r_ramp <= n_ramp;
                        r_phold <= n_phold; r_dhold <= n_dhold; r_stc <= n_stc;
                        r_acode <= n_acode; r_pcode <= n_pcode; r_ph <= n_ph;
                        r_atim <= n_atim; r_ptim <= n_ptim; r_ashp <= n_ashp;
                        r_pshp <= n_pshp; r_fleft <= n_fleft; r_bri <= n_bri;
                        r_bstep <= n_bstep; r_duty <= n_duty;
                        r_mul_br <= n_mul_br; r_mul_x <= n_mul_x;
                        r_lvl <= w_lvl;
                        r_st <= n_mul ? S_MUL1 : S_OUT;
                    end
                end
                S_MUL1: begin
                    r_prod <= w_p1;
                    if (r_mul_br) r_st <= S_MUL2;
                    else begin
                        r_duty <= 16'(w_p1 >> LEVEL_BITS);
                        r_st <= S_OUT;
                    end
                end
                S_MUL2: begin
                    r_duty <= 16'(w_p2 >> LEVEL_BITS);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_oitem.pwm_duty <= r_duty;
                    r_oitem.mode <= r_mode;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/led_pwm_animation_controller.sv]
// Top level of the LED PWM animation controller
`timescale 1ns / 1ps
// Each accepted transaction passes through the queue and the back end's states
// S_IDLE, S_MUL1 and S_MUL2 where products are needed, then S_OUT, which registers
// the result; a new one is popped only in S_IDLE and not while a result is stalled.
// A two-entry queue separates input acceptance from the sequencer.
// Reset (i_rst_n low, synchronous) clears mode, slots, queue and max_pulse.
module led_pwm_animation_controller #(
    parameter int RAMP_STEP_BITS = lpa_pkg::RampStepBitsDef,
    parameter int BRIGHT_BITS    = lpa_pkg::BrightBitsDef,
    parameter int LEVEL_BITS     = lpa_pkg::LevelBitsDef,
    parameter int TICK_BITS      = lpa_pkg::TickBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lpa_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output lpa_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);
    import lpa_pkg::*;

    logic [15:0] r_max_pulse;
    logic        w_q_valid, w_q_pop;
    t_work       w_q_work;

    // max_pulse register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_pulse <= '0;
        else if (i_cfg_we) r_max_pulse <= i_cfg_data;
    end

    lpa_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_q_valid(w_q_valid), .o_q_work(w_q_work), .i_q_pop(w_q_pop)
    );

    lpa_back #(
        .RAMP_STEP_BITS(RAMP_STEP_BITS), .BRIGHT_BITS(BRIGHT_BITS),
        .LEVEL_BITS(LEVEL_BITS), .TICK_BITS(TICK_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_max_pulse(r_max_pulse),
        .i_q_valid(w_q_valid), .i_q_work(w_q_work), .o_q_pop(w_q_pop),
        .o_valid, .i_stall, .o_item
    );
endmodule

[hdl/lpa_checker.sv]
// Port-level checker for the LED PWM animation controller, with its bind
`timescale 1ns / 1ps
`include "led_pwm_animation_controller_defines.svh"
module lpa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input lpa_pkg::t_out_item o_item
);
    `LPA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_item), "result changed while stalled")
    `LPA_ASSERT_NXT(a_out_gap, i_clk, i_rst_n, o_valid && !i_stall, !o_valid, "results back to back")
    `LPA_ASSERT_IMP(a_rst_clean, i_clk, 1'b1, !$past(i_rst_n), !o_valid && !o_stall, "not idle after reset")
endmodule

bind led_pwm_animation_controller lpa_checker u_lpa_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_item
);

[tb/lpa_checker.sv]
// Scoreboard for the LED animation controller: predicts and compares results
`timescale 1ns / 1ps
module lpa_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  lpa_pkg::t_in_item  i_item,
    input  logic               o_valid,
    input  logic               i_stall,
    input  lpa_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_waiting
);
    import lpa_pkg::*;

    // predictor state
    logic [15:0] pulse_max;
    logic [1:0]  cur_mode;
    logic        configured;
    logic [15:0] tick_cnt;
    logic [2:0]  act_code, pend_code;
    logic [47:0] act_tim, pend_tim;
    logic [16:0] act_shape, pend_shape;
    logic [7:0]  flashes;
    logic        lit;
    logic [2:0]  phase;
    longint      tps, ramp, hold_pk, hold_dk, step_cnt, bright, bstep;
    logic [15:0] duty_reg;

    t_out_item expected_q[$];

    function automatic logic [15:0] scale_level(input logic [7:0] lvl);
        longint v;
        v = (longint'(pulse_max) * lvl) >> 8;
        return v[15:0];
    endfunction

    function automatic logic [15:0] breath_level(input logic [7:0] lvl);
        longint v;
        v = (longint'(pulse_max) * bright) >> 16;
        v = (v * lvl) >> 8;
        return v[15:0];
    endfunction

    function automatic longint tim_field(input int k);
        return longint'(act_tim >> (16 * k)) & 64'hFFFF;
    endfunction

    function automatic longint clamp_hold(input longint h, input longint err);
        longint v;
        v = h + err;
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    task automatic promote_pending();
        if (pend_code != 0) begin
            act_code = pend_code;
            act_tim = pend_tim;
            act_shape = pend_shape;
            pend_code = 0;
            pend_tim = 0;
            pend_shape = 0;
        end
    endtask

    task automatic turn_off();
        cur_mode = M_OFF;
        configured = 0;
        tick_cnt = 0;
    endtask

    task automatic ramp_step(input logic [7:0] lvl);
        step_cnt = (step_cnt + 1) & 64'hFFFF;
        if (step_cnt < tps) return;
        if (phase == PH_IN) begin
            bright += bstep;
            if (bright > 65536) bright = 65536;
            bstep += 2;
        end else if (bright >= bstep) begin
            bright -= bstep;
            if (bstep > 1) bstep -= 2;
        end
        duty_reg = breath_level(lvl);
        step_cnt = 0;
    endtask

    task automatic breath_setup();
        longint per, hin, hout, half;
        per = tim_field(0);
        hin = tim_field(1);
        hout = tim_field(2);
        half = (hin + hout > per) ? 0 : (per - hin - hout) / 2;
        tps = (half + 128) >> 8;
        ramp = (tps << 8) & 64'hFFFF;
        hold_pk = clamp_hold(hin, half - ramp);
        hold_dk = clamp_hold(hout, half - ramp);
        step_cnt = 0;
        bstep = 1;
        bright = 0;
        tick_cnt = ramp[15:0];
        phase = PH_IN;
        configured = 1;
    endtask

    task automatic advance_tick();
        logic [7:0] lvl, times;
        logic       st_on;
        lvl = act_shape[7:0];
        times = act_shape[15:8];
        st_on = act_shape[16];
        if (tick_cnt > 0) tick_cnt--;
        if (cur_mode == M_OFF) begin
            if (!configured) begin
                duty_reg = 0;
                if (act_code == 1) act_code = 0;
                configured = 1;
            end
            if (act_code >= 2) begin
                cur_mode = 2'(act_code - 3'd1);
                act_code = 0;
                configured = 0;
                tick_cnt = 0;
            end
            return;
        end
        if (act_code != 0) begin
            turn_off();
            return;
        end
        if (cur_mode == M_SOLID) begin
            if (!configured) begin
                duty_reg = scale_level(lvl);
                configured = 1;
            end
            promote_pending();
            return;
        end
        if (cur_mode == M_FLASH) begin
            if (!configured) begin
                flashes = times;
                if (st_on) begin
                    tick_cnt = 16'(tim_field(0));
                    duty_reg = scale_level(lvl);
                    lit = 1;
                end else begin
                    tick_cnt = 16'(tim_field(1));
                    duty_reg = 0;
                    lit = 0;
                end
                configured = 1;
            end
            if (times[7]) flashes = 8'hFF;
            if (tick_cnt == 0) begin
                if (flashes == 0) begin
                    promote_pending();
                    turn_off();
                    return;
                end
                if (lit) begin
                    duty_reg = 0;
                    lit = 0;
                    tick_cnt = 16'(tim_field(1));
                    if (st_on) flashes--;
                end else begin
                    duty_reg = scale_level(lvl);
                    lit = 1;
                    tick_cnt = 16'(tim_field(0));
                    if (!st_on) flashes--;
                end
            end
            return;
        end
        if (!configured) begin
            breath_setup();
            return;
        end
        case (phase)
            PH_IN: begin
                if (tick_cnt == 0) begin
                    duty_reg = scale_level(lvl);
                    tick_cnt = hold_pk[15:0];
                    step_cnt = 0;
                    bstep = (bstep >= 2) ? bstep - 2 : 0;
                    phase = PH_HOLDIN;
                end else ramp_step(lvl);
            end
            PH_HOLDIN: begin
                if (tick_cnt == 0) begin
                    tick_cnt = ramp[15:0];
                    phase = PH_OUT;
                end
            end
            PH_OUT: begin
                if (tick_cnt == 0) begin
                    duty_reg = 0;
                    tick_cnt = hold_dk[15:0];
                    step_cnt = 0;
                    bstep = 1;
                    bright = 0;
                    phase = PH_HOLDOUT;
                end else ramp_step(lvl);
            end
            PH_HOLDOUT: begin
                if (tick_cnt == 0) begin
                    tick_cnt = ramp[15:0];
                    phase = PH_DONE;
                    promote_pending();
                end
            end
            default: cur_mode = M_OFF;
        endcase
    endtask

    task automatic predict_led(input t_in_item it);
        logic [47:0] tim;
        logic [16:0] shp;
        t_out_item   res;
        if (it.kind == KIND_TICK) begin
            advance_tick();
        end else begin
            tim = 0;
            shp = 0;
            if (it.command == M_SOLID || it.command == M_BREATH) shp[7:0] = it.duty;
            if (it.command == M_FLASH) begin
                tim = {16'd0, it.off_ticks, it.on_ticks};
                shp = {it.start_on, it.flash_times, it.duty};
            end
            if (it.command == M_BREATH)
                tim = {it.hold_out_ticks, it.hold_in_ticks, it.period_ticks};
            if (it.force_now) begin
                act_code = {1'b0, it.command} + 3'd1;
                act_tim = tim;
                act_shape = shp;
            end else begin
                pend_code = {1'b0, it.command} + 3'd1;
                pend_tim = tim;
                pend_shape = shp;
            end
        end
        res.pwm_duty = duty_reg;
        res.mode = cur_mode;
        expected_q.push_back(res);
    endtask

    assign o_waiting = expected_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pulse_max <= 0;
            cur_mode = M_OFF; configured = 0; tick_cnt = 0;
            act_code = 0; act_tim = 0; act_shape = 0;
            pend_code = 0; pend_tim = 0; pend_shape = 0;
            flashes = 0; lit = 0; phase = PH_IN;
            tps = 0; ramp = 0; hold_pk = 0; hold_dk = 0;
            step_cnt = 0; bright = 0; bstep = 1; duty_reg = 0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) pulse_max <= i_cfg_data;
            if (i_valid && !o_stall) predict_led(i_item);
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", o_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== o_item) begin
                        if (o_errors < 10)
                            $display("duty exp %0d got %0d, mode exp %0d got %0d",
                                want.pwm_duty, o_item.pwm_duty, want.mode, o_item.mode);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// Testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb;
    import lpa_pkg::*;

    localparam int InBits = $bits(t_in_item);

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_out_item   o_item;
    logic        i_cfg_we = 0;
    logic [15:0] i_cfg_data = 0;
    int          fail_count, pending_results;
    int          cycle_cnt = 0;
    int          idle_pct = 13;   // idle/stall percentage, zero in quiet stretches
    bit          hold_off = 0;    // long receiver stall for the fill-up test

    always #1 i_clk = ~i_clk;

    led_pwm_animation_controller DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_valid, .i_stall, .o_item, .i_cfg_we, .i_cfg_data
    );

    lpa_scoreboard scoreboard (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item, .o_valid, .i_stall,
        .o_item, .i_cfg_we, .i_cfg_data,
        .o_errors(fail_count), .o_waiting(pending_results)
    );

    // Watchdog: the worst case, idling included, stays far under this limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("led_pwm_animation_controller: mismatch");
            $finish;
        end
    end

    // Receiver stall: random, or held for the fill-up stretch.
    always @(posedge i_clk)
        i_stall <= hold_off || ($urandom_range(99) < idle_pct);

    // Random timing, biased toward short values so sequences actually finish.
    function automatic logic [15:0] rnd_ticks();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'($urandom);
            2, 3: return 0;
            default: return 16'($urandom_range(6));
        endcase
    endfunction

    function automatic t_in_item rnd_cmd(input logic [1:0] c, input logic f);
        t_in_item it;
        it = t_in_item'(InBits'({$urandom, $urandom, $urandom, $urandom}));
        it.kind = KIND_CMD;
        it.command = c;
        it.force_now = f;
        it.on_ticks = rnd_ticks();
        it.off_ticks = rnd_ticks();
        it.hold_in_ticks = rnd_ticks();
        it.hold_out_ticks = rnd_ticks();
        it.period_ticks = ($urandom_range(9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(1200));
        if ($urandom_range(3) != 0) it.flash_times = 8'($urandom_range(3));
        return it;
    endfunction

    function automatic t_in_item tick_item();
        t_in_item it;
        it = t_in_item'(InBits'({$urandom, $urandom, $urandom, $urandom}));
        it.kind = KIND_TICK;
        return it;
    endfunction

    // Offer one transaction and wait until it is accepted; valid is left
    // high so the next transaction can follow without a gap.
    task automatic send(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send(tick_item());
    endtask

    // Drain results, then let the block settle before a register write.
    task automatic set_pulse(input logic [15:0] v);
        i_valid <= 0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    initial begin
        t_in_item it;
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: full scale, every command, forced and pending paths
        set_pulse(16'hFFFF);
        send_ticks(2);
        send(rnd_cmd(M_SOLID, 0));              // pending while off is not taken
        send_ticks(2);
        it = rnd_cmd(M_SOLID, 1); it.duty = 8'hFF; send(it);
        send_ticks(3);
        it = rnd_cmd(M_FLASH, 0); it.flash_times = 8'sd2; it.start_on = 1;
        it.on_ticks = 2; it.off_ticks = 1; send(it);
        send_ticks(3);
        it = rnd_cmd(M_FLASH, 1); it.flash_times = -8'sd1; it.start_on = 0;
        it.on_ticks = 0; it.off_ticks = 16'hFFFF; send(it);
        send_ticks(3);
        it = rnd_cmd(M_OFF, 1); send(it);       // forced off
        send_ticks(3);
        it = rnd_cmd(M_BREATH, 1); it.period_ticks = 16'hFFFF;
        it.hold_in_ticks = 16'hFFFF; it.hold_out_ticks = 0; it.duty = 0; send(it);
        send_ticks(4);

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_pulse(16'h0000);
                1: set_pulse(16'hFFFF);
                default: set_pulse(16'($urandom));
            endcase
            idle_pct = (ph == 3) ? 0 : 13;
            if (ph == 4) fork
                begin
                    hold_off = 1;
                    repeat (60) @(posedge i_clk);
                    hold_off = 0;
                end
            join_none
            for (int n = 0; n < 200; n++) begin
                r = $urandom_range(99);
                if (r < 70) send(tick_item());
                else if (r < 82) send(rnd_cmd(2'($urandom), 1));
                else if (r < 95) send(rnd_cmd(2'($urandom), 0));
                else send(t_in_item'(InBits'({$urandom, $urandom, $urandom, $urandom})));
            end
        end

        i_valid <= 0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("led_pwm_animation_controller: match");
        else
            $display("led_pwm_animation_controller: mismatch");
        $finish;
    end
endmodule

[led_pwm_animation_controller.f]
+incdir+hdl
hdl/lpa_pkg.sv
hdl/lpa_front.sv
hdl/lpa_back.sv
hdl/led_pwm_animation_controller.sv
hdl/lpa_checker.sv
tb/lpa_checker.sv
tb/tb.sv
